// ===== src/pinhole_projection_with_distortion_assert.svh =====
// ---------------------------------------------------------------------------
// Pinhole projection assertion macros
// Shared concurrent assertion forms; they expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef PINHOLE_PROJECTION_WITH_DISTORTION_ASSERT_SVH
`define PINHOLE_PROJECTION_WITH_DISTORTION_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define PHD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pinhole projection assertion failed");

// condition holds in the cycle after the trigger
`define PHD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pinhole projection assertion failed");

`endif

// ===== src/phd_pkg.sv =====
// ---------------------------------------------------------------------------
// phd_pkg
// Types, constants and saturation helpers of the projection pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package phd_pkg;

  // normalised quantities carry this many fraction bits
  localparam int NORM_FRAC  = 30;
  localparam int VAL_W      = 62;              // holds +-2^60
  localparam int SUM_W      = 64;              // sums of a few values
  localparam int MAG_W      = 61;              // magnitude of a value
  localparam int DIV_BITS   = 32 + NORM_FRAC;  // quotient bits
  localparam int DEN_W      = 31;              // positive depth
  localparam int MUL_LAT    = 4;               // multiplier stages
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 56;
  localparam int PP_W       = 28;

  typedef logic signed [VAL_W-1:0] phd_val_t;
  typedef logic signed [SUM_W-1:0] phd_sum_t;

  typedef struct packed {
    logic vld;
    logic zbad;
    logic ovf;
  } phd_ctl_t;

  localparam phd_sum_t LIM_POS     = 64'sh1000_0000_0000_0000;
  localparam phd_sum_t LIM_NEG     = 64'shF000_0000_0000_0000;
  localparam phd_val_t LIM_VAL_POS = 62'sh1000_0000_0000_0000;
  localparam phd_val_t LIM_VAL_NEG = -LIM_VAL_POS;
  localparam phd_sum_t ONE_NORM    = 64'sh0000_0000_4000_0000;
  localparam phd_sum_t PIX_MAX     = 64'sh0000_0000_7FFF_FFFF;
  localparam phd_sum_t PIX_MIN     = 64'shFFFF_FFFF_8000_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_K1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_K2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FY = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PP = 3'd7;

  // clamp a sum to +-2^60
  function automatic phd_val_t lim_val(input phd_sum_t v);
    phd_val_t r;
    if (v > LIM_POS) begin
      r = LIM_VAL_POS;
    end else if (v < LIM_NEG) begin
      r = LIM_VAL_NEG;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic lim_ovf(input phd_sum_t v);
    return (v > LIM_POS) || (v < LIM_NEG);
  endfunction

  // quotient beyond 2^60
  function automatic logic div_ovf(input logic [DIV_BITS-1:0] q);
    return (|q[DIV_BITS-1:MAG_W]) || (q[MAG_W-1] && (|q[MAG_W-2:0]));
  endfunction

  // clamped, signed quotient
  function automatic phd_val_t div_val(input logic [DIV_BITS-1:0] q, input logic neg);
    logic [MAG_W-1:0] mag;
    phd_val_t         pos;
    mag = div_ovf(q) ? LIM_VAL_POS[MAG_W-1:0] : q[MAG_W-1:0];
    pos = {1'b0, mag};
    return neg ? -pos : pos;
  endfunction

  function automatic phd_ctl_t ctl_or(input phd_ctl_t c, input logic o);
    phd_ctl_t r;
    r     = c;
    r.ovf = c.ovf | o;
    return r;
  endfunction

endpackage

// ===== src/pinhole_projection_with_distortion.sv =====
// Throughput: one word per cycle; a stall at the output freezes the whole pipeline.
// The datapath holds the 62-stage divider (one quotient bit per stage) and six
// four-stage multiplier rows. Reset (rst_n, synchronous) empties the pipeline and
// sets the coefficients to zero, focal lengths to 1.0 and the principal point to 0.
// ---------------------------------------------------------------------------
// pinhole_projection_with_distortion
// Pinhole camera projection with radial and tangential lens distortion.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pinhole_projection_with_distortion #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int COEFF_FRAC_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [95:0]                    in_tdata,   // local_x, local_y, local_z
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // pixel_x, pixel_y
  output logic [0:0]                     out_tuser,  // valid_res
  input  logic                           cfg_wr_en,
  input  logic [phd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [phd_pkg::CFG_DATA_W-1:0] cfg_data
);

  import phd_pkg::*;

  localparam int L        = MUL_LAT;
  localparam int XN_DLY   = 4 * L + 2;
  localparam int CTL_W    = $bits(phd_ctl_t);
  localparam logic [31:0] FOCAL_ONE = 32'(1) << COORD_FRAC_BITS;

  // configuration registers
  logic [31:0]      k1_r, k2_r, k3_r, p1_r, p2_r, fx_r, fy_r;
  logic [CFG_DATA_W-1:0] pp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r <= '0;
      k2_r <= '0;
      k3_r <= '0;
      p1_r <= '0;
      p2_r <= '0;
      fx_r <= FOCAL_ONE;
      fy_r <= FOCAL_ONE;
      pp_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_K1:  k1_r <= cfg_data[31:0];
        REG_K2:  k2_r <= cfg_data[31:0];
        REG_K3:  k3_r <= cfg_data[31:0];
        REG_P1:  p1_r <= cfg_data[31:0];
        REG_P2:  p2_r <= cfg_data[31:0];
        REG_FX:  fx_r <= cfg_data[31:0];
        REG_FY:  fy_r <= cfg_data[31:0];
        REG_PP:  pp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  phd_val_t k1_v, k2_v, k3_v, p1_v, p2_v, fx_v, fy_v;
  assign k1_v = {{(VAL_W-32){k1_r[31]}}, k1_r};
  assign k2_v = {{(VAL_W-32){k2_r[31]}}, k2_r};
  assign k3_v = {{(VAL_W-32){k3_r[31]}}, k3_r};
  assign p1_v = {{(VAL_W-32){p1_r[31]}}, p1_r};
  assign p2_v = {{(VAL_W-32){p2_r[31]}}, p2_r};
  assign fx_v = {{(VAL_W-32){1'b0}}, fx_r};
  assign fy_v = {{(VAL_W-32){1'b0}}, fy_r};

  // global advance: the whole pipeline moves unless a result waits
  logic en, out_vld_r;
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // input register
  logic               in_vld_r;
  logic signed [31:0] in_x_r, in_y_r, in_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_x_r <= in_tdata[31:0];
      in_y_r <= in_tdata[63:32];
      in_z_r <= in_tdata[95:64];
    end
  end

  // divider feed: magnitudes, signs, depth check
  logic                zbad;
  logic [31:0]         ux, uy;
  phd_ctl_t            pre_ctl_nxt, pre_ctl_r;
  logic [DIV_BITS-1:0] pre_dx_r, pre_dy_r;
  logic [DEN_W-1:0]    pre_den_r;
  logic                pre_sx_r, pre_sy_r;

  assign zbad = in_z_r[31] || (in_z_r == '0);
  assign ux   = in_x_r[31] ? (~in_x_r + 32'd1) : in_x_r;
  assign uy   = in_y_r[31] ? (~in_y_r + 32'd1) : in_y_r;

  always_comb begin
    pre_ctl_nxt      = '0;
    pre_ctl_nxt.vld  = in_vld_r;
    pre_ctl_nxt.zbad = zbad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_ctl_r <= '0;
    end else if (en) begin
      pre_ctl_r <= pre_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_dx_r  <= zbad ? '0 : {ux, {NORM_FRAC{1'b0}}};
      pre_dy_r  <= zbad ? '0 : {uy, {NORM_FRAC{1'b0}}};
      pre_den_r <= zbad ? DEN_W'(1) : in_z_r[DEN_W-1:0];
      pre_sx_r  <= in_x_r[31];
      pre_sy_r  <= in_y_r[31];
    end
  end

  // x/z and y/z
  logic [DIV_BITS-1:0] qx, qy;
  logic [CTL_W+1:0]    div_side;

  phd_div u_div_x (.clk(clk), .en(en), .dvd(pre_dx_r), .den(pre_den_r), .quo(qx));
  phd_div u_div_y (.clk(clk), .en(en), .dvd(pre_dy_r), .den(pre_den_r), .quo(qy));

  phd_dly #(.W(CTL_W + 2), .DEPTH(DIV_BITS)) u_dly_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({pre_sx_r, pre_sy_r, pre_ctl_r}), .q(div_side)
  );

  // clamp and sign the quotients
  phd_val_t xn_r, yn_r;
  phd_ctl_t c0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r <= '0;
    end else if (en) begin
      c0_r <= ctl_or(phd_ctl_t'(div_side[CTL_W-1:0]), div_ovf(qx) | div_ovf(qy));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xn_r <= div_val(qx, div_side[CTL_W+1]);
      yn_r <= div_val(qy, div_side[CTL_W]);
    end
  end

  // row 1: x^2, y^2, xy
  phd_val_t x2_p, y2_p, xy_p;
  logic     ov_x2, ov_y2, ov_xy;
  logic [CTL_W-1:0] c1_d;

  phd_mul #(.SHIFT(NORM_FRAC)) u_m_x2 (.clk(clk), .en(en), .a(xn_r), .b(xn_r),
    .p(x2_p), .ovf(ov_x2));
  phd_mul #(.SHIFT(NORM_FRAC)) u_m_y2 (.clk(clk), .en(en), .a(yn_r), .b(yn_r),
    .p(y2_p), .ovf(ov_y2));
  phd_mul #(.SHIFT(NORM_FRAC)) u_m_xy (.clk(clk), .en(en), .a(xn_r), .b(yn_r),
    .p(xy_p), .ovf(ov_xy));

  phd_dly #(.W(CTL_W), .DEPTH(L)) u_dly_c1 (.clk(clk), .rst_n(rst_n), .en(en),
    .d(c0_r), .q(c1_d));

  // r^2
  phd_sum_t r2_s;
  phd_val_t r2_r, x2_r, y2_r, xy_r;
  phd_ctl_t ca_r;

  assign r2_s = phd_sum_t'(x2_p) + phd_sum_t'(y2_p);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= '0;
    end else if (en) begin
      ca_r <= ctl_or(phd_ctl_t'(c1_d), ov_x2 | ov_y2 | ov_xy | lim_ovf(r2_s));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r <= lim_val(r2_s);
      x2_r <= x2_p;
      y2_r <= y2_p;
      xy_r <= xy_p;
    end
  end

  // row 2: r^4, k1*r^2
  phd_val_t r4_p, k1r2_p;
  logic     ov_r4, ov_k1r2;

  phd_mul #(.SHIFT(NORM_FRAC)) u_m_r4 (.clk(clk), .en(en), .a(r2_r), .b(r2_r),
    .p(r4_p), .ovf(ov_r4));
  phd_mul #(.SHIFT(COEFF_FRAC_BITS)) u_m_k1 (.clk(clk), .en(en), .a(k1_v), .b(r2_r),
    .p(k1r2_p), .ovf(ov_k1r2));

  // tangential terms r^2 + 2x^2 and r^2 + 2y^2
  phd_sum_t tx_s, ty_s;
  phd_val_t tx_r, ty_r;
  phd_ctl_t cb_r;

  assign tx_s = phd_sum_t'(r2_r) + (phd_sum_t'(x2_r) <<< 1);
  assign ty_s = phd_sum_t'(r2_r) + (phd_sum_t'(y2_r) <<< 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_r <= '0;
    end else if (en) begin
      cb_r <= ctl_or(ca_r, lim_ovf(tx_s) | lim_ovf(ty_s));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r <= lim_val(tx_s);
      ty_r <= lim_val(ty_s);
    end
  end

  // align operands for row 3
  logic [2*VAL_W-1:0] r2xy_d, txty_d;
  logic [CTL_W-1:0]   cb_d;
  phd_val_t           r2_c, xy_c, tx_c, ty_c;
  phd_ctl_t           cc;

  phd_dly #(.W(2 * VAL_W), .DEPTH(L)) u_dly_r2xy (.clk(clk), .rst_n(rst_n), .en(en),
    .d({r2_r, xy_r}), .q(r2xy_d));
  phd_dly #(.W(2 * VAL_W), .DEPTH(L - 1)) u_dly_t (.clk(clk), .rst_n(rst_n), .en(en),
    .d({tx_r, ty_r}), .q(txty_d));
  phd_dly #(.W(CTL_W), .DEPTH(L - 1)) u_dly_cb (.clk(clk), .rst_n(rst_n), .en(en),
    .d(cb_r), .q(cb_d));

  assign r2_c = r2xy_d[2*VAL_W-1:VAL_W];
  assign xy_c = r2xy_d[VAL_W-1:0];
  assign tx_c = txty_d[2*VAL_W-1:VAL_W];
  assign ty_c = txty_d[VAL_W-1:0];
  assign cc   = ctl_or(phd_ctl_t'(cb_d), ov_r4 | ov_k1r2);

  // row 3: r^6, k2*r^4 and the four tangential products
  phd_val_t r6_p, k2r4_p, p1xy_p, p2xy_p, p2tx_p, p1ty_p, k1r2_d;
  logic     ov_r6, ov_k2r4, ov_p1xy, ov_p2xy, ov_p2tx, ov_p1ty;
  logic [CTL_W-1:0] cc_d;
  phd_ctl_t cd;

  phd_mul #(.SHIFT(NORM_FRAC)) u_m_r6 (.clk(clk), .en(en), .a(r4_p), .b(r2_c),
    .p(r6_p), .ovf(ov_r6));
  phd_mul #(.SHIFT(COEFF_FRAC_BITS)) u_m_k2 (.clk(clk), .en(en), .a(k2_v), .b(r4_p),
    .p(k2r4_p), .ovf(ov_k2r4));
  phd_mul #(.SHIFT(COEFF_FRAC_BITS)) u_m_p1xy (.clk(clk), .en(en), .a(p1_v), .b(xy_c),
    .p(p1xy_p), .ovf(ov_p1xy));
  phd_mul #(.SHIFT(COEFF_FRAC_BITS)) u_m_p2xy (.clk(clk), .en(en), .a(p2_v), .b(xy_c),
    .p(p2xy_p), .ovf(ov_p2xy));
  phd_mul #(.SHIFT(COEFF_FRAC_BITS)) u_m_p2tx (.clk(clk), .en(en), .a(p2_v), .b(tx_c),
    .p(p2tx_p), .ovf(ov_p2tx));
  phd_mul #(.SHIFT(COEFF_FRAC_BITS)) u_m_p1ty (.clk(clk), .en(en), .a(p1_v), .b(ty_c),
    .p(p1ty_p), .ovf(ov_p1ty));

  phd_dly #(.W(VAL_W), .DEPTH(L)) u_dly_k1 (.clk(clk), .rst_n(rst_n), .en(en),
    .d(k1r2_p), .q(k1r2_d));
  phd_dly #(.W(CTL_W), .DEPTH(L)) u_dly_cc (.clk(clk), .rst_n(rst_n), .en(en),
    .d(cc), .q(cc_d));

  assign cd = ctl_or(phd_ctl_t'(cc_d),
                     ov_r6 | ov_k2r4 | ov_p1xy | ov_p2xy | ov_p2tx | ov_p1ty);

  // row 4: k3*r^6, with the other terms held alongside
  phd_val_t k3r6_p;
  logic     ov_k3r6;
  logic [6*VAL_W-1:0] terms_d;
  logic [CTL_W-1:0]   cd_d;
  phd_val_t k1r2_e, k2r4_e, p1xy_e, p2xy_e, p2tx_e, p1ty_e;

  phd_mul #(.SHIFT(COEFF_FRAC_BITS)) u_m_k3 (.clk(clk), .en(en), .a(k3_v), .b(r6_p),
    .p(k3r6_p), .ovf(ov_k3r6));

  phd_dly #(.W(6 * VAL_W), .DEPTH(L)) u_dly_terms (.clk(clk), .rst_n(rst_n), .en(en),
    .d({k1r2_d, k2r4_p, p1xy_p, p2xy_p, p2tx_p, p1ty_p}), .q(terms_d));
  phd_dly #(.W(CTL_W), .DEPTH(L)) u_dly_cd (.clk(clk), .rst_n(rst_n), .en(en),
    .d(cd), .q(cd_d));

  assign k1r2_e = terms_d[6*VAL_W-1:5*VAL_W];
  assign k2r4_e = terms_d[5*VAL_W-1:4*VAL_W];
  assign p1xy_e = terms_d[4*VAL_W-1:3*VAL_W];
  assign p2xy_e = terms_d[3*VAL_W-1:2*VAL_W];
  assign p2tx_e = terms_d[2*VAL_W-1:VAL_W];
  assign p1ty_e = terms_d[VAL_W-1:0];

  // radial factor and tangential offsets
  phd_sum_t rad_s;
  phd_val_t radial_r;
  phd_sum_t dxt_r, dyt_r;
  phd_ctl_t ce_r;

  assign rad_s = ONE_NORM + phd_sum_t'(k1r2_e) + phd_sum_t'(k2r4_e) + phd_sum_t'(k3r6_p);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ce_r <= '0;
    end else if (en) begin
      ce_r <= ctl_or(phd_ctl_t'(cd_d), ov_k3r6 | lim_ovf(rad_s));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      radial_r <= lim_val(rad_s);
      dxt_r    <= (phd_sum_t'(p1xy_e) <<< 1) + phd_sum_t'(p2tx_e);
      dyt_r    <= phd_sum_t'(p1ty_e) + (phd_sum_t'(p2xy_e) <<< 1);
    end
  end

  // row 5: xn*radial, yn*radial
  logic [2*VAL_W-1:0] xnyn_d;
  phd_val_t xn_e, yn_e, xr_p, yr_p;
  logic     ov_xr, ov_yr;
  logic [2*SUM_W-1:0] dt_d;
  logic [CTL_W-1:0]   ce_d;
  phd_sum_t dx_s, dy_s;

  phd_dly #(.W(2 * VAL_W), .DEPTH(XN_DLY)) u_dly_xn (.clk(clk), .rst_n(rst_n), .en(en),
    .d({xn_r, yn_r}), .q(xnyn_d));

  assign xn_e = xnyn_d[2*VAL_W-1:VAL_W];
  assign yn_e = xnyn_d[VAL_W-1:0];

  phd_mul #(.SHIFT(NORM_FRAC)) u_m_xr (.clk(clk), .en(en), .a(xn_e), .b(radial_r),
    .p(xr_p), .ovf(ov_xr));
  phd_mul #(.SHIFT(NORM_FRAC)) u_m_yr (.clk(clk), .en(en), .a(yn_e), .b(radial_r),
    .p(yr_p), .ovf(ov_yr));

  phd_dly #(.W(2 * SUM_W), .DEPTH(L)) u_dly_dt (.clk(clk), .rst_n(rst_n), .en(en),
    .d({dxt_r, dyt_r}), .q(dt_d));
  phd_dly #(.W(CTL_W), .DEPTH(L)) u_dly_ce (.clk(clk), .rst_n(rst_n), .en(en),
    .d(ce_r), .q(ce_d));

  assign dx_s = phd_sum_t'(xr_p) + phd_sum_t'(dt_d[2*SUM_W-1:SUM_W]);
  assign dy_s = phd_sum_t'(yr_p) + phd_sum_t'(dt_d[SUM_W-1:0]);

  // distorted coordinates
  phd_val_t dx_r, dy_r;
  phd_ctl_t cf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cf_r <= '0;
    end else if (en) begin
      cf_r <= ctl_or(phd_ctl_t'(ce_d), ov_xr | ov_yr | lim_ovf(dx_s) | lim_ovf(dy_s));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= lim_val(dx_s);
      dy_r <= lim_val(dy_s);
    end
  end

  // row 6: focal scaling
  phd_val_t fdx_p, fdy_p;
  logic     ov_fdx, ov_fdy;
  logic [CTL_W-1:0] cf_d;
  phd_ctl_t co;

  phd_mul #(.SHIFT(NORM_FRAC)) u_m_fx (.clk(clk), .en(en), .a(fx_v), .b(dx_r),
    .p(fdx_p), .ovf(ov_fdx));
  phd_mul #(.SHIFT(NORM_FRAC)) u_m_fy (.clk(clk), .en(en), .a(fy_v), .b(dy_r),
    .p(fdy_p), .ovf(ov_fdy));

  phd_dly #(.W(CTL_W), .DEPTH(L)) u_dly_cf (.clk(clk), .rst_n(rst_n), .en(en),
    .d(cf_r), .q(cf_d));

  assign co = ctl_or(phd_ctl_t'(cf_d), ov_fdx | ov_fdy);

  // principal point, pixel clamp and output word
  phd_sum_t    px_s, py_s;
  logic        px_hi, px_lo, py_hi, py_lo;
  logic [31:0] px_nxt, py_nxt, px_r, py_r;
  logic        flag_nxt, flag_r;

  assign px_s  = phd_sum_t'(fdx_p) + phd_sum_t'({{(SUM_W-PP_W){1'b0}}, pp_r[2*PP_W-1:PP_W]});
  assign py_s  = phd_sum_t'(fdy_p) + phd_sum_t'({{(SUM_W-PP_W){1'b0}}, pp_r[PP_W-1:0]});
  assign px_hi = px_s > PIX_MAX;
  assign px_lo = px_s < PIX_MIN;
  assign py_hi = py_s > PIX_MAX;
  assign py_lo = py_s < PIX_MIN;

  always_comb begin
    if (co.zbad) begin
      px_nxt   = '0;
      py_nxt   = '0;
      flag_nxt = 1'b0;
    end else begin
      px_nxt   = px_hi ? 32'h7FFF_FFFF : (px_lo ? 32'h8000_0000 : px_s[31:0]);
      py_nxt   = py_hi ? 32'h7FFF_FFFF : (py_lo ? 32'h8000_0000 : py_s[31:0]);
      flag_nxt = !(co.ovf | px_hi | px_lo | py_hi | py_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= co.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      flag_r <= flag_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {py_r, px_r};
  assign out_tuser  = flag_r;

  // checks
`include "pinhole_projection_with_distortion_assert.svh"

  // a frozen pipeline keeps the control word behind the divider
  `PHD_ASSERT_NXT(a_hold_on_stall, !en, $stable(c0_r))
  // a rejected depth feeds zero numerators through the divider
  `PHD_ASSERT_IMP(a_zbad_zero, c0_r.vld && c0_r.zbad, (xn_r == '0) && (yn_r == '0))

endmodule

// ===== src/phd_dly.sv =====
// ---------------------------------------------------------------------------
// phd_dly
// Enabled shift line that keeps side data aligned with the pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module phd_dly #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [DEPTH];

  // shift on every enabled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) sr_r[i] <= '0;
    end else if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

// ===== src/phd_mul.sv =====
// ---------------------------------------------------------------------------
// phd_mul
// Four-stage signed multiply, scaled by 2^-SHIFT with rounding half away
// from zero and clamped to +-2^60.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module phd_mul #(
  parameter int SHIFT = 30
) (
  input  logic              clk,
  input  logic              en,
  input  phd_pkg::phd_val_t a,
  input  phd_pkg::phd_val_t b,
  output phd_pkg::phd_val_t p,
  output logic              ovf
);

  import phd_pkg::*;

  localparam int LO_W   = 32;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int PROD_W = 2 * MAG_W + 1;
  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (SHIFT - 1);

  logic [VAL_W-1:0]       na, nb;
  logic [MAG_W-1:0]       ua_r, ub_r;
  logic                   neg1_r, neg2_r, neg3_r;
  logic [2*LO_W-1:0]      ll_r;
  logic [LO_W+HI_W-1:0]   lh_r, hl_r;
  logic [2*HI_W-1:0]      hh_r;
  logic [PROD_W-1:0]      sum_nxt, sum_r, shf;
  logic                   ovf_nxt;
  logic [MAG_W-1:0]       mag;
  phd_val_t               p_nxt, p_r;
  logic                   ovf_r;

  assign na = -a;
  assign nb = -b;

  // stage 1: magnitudes and sign
  always_ff @(posedge clk) begin
    if (en) begin
      ua_r   <= a[VAL_W-1] ? na[MAG_W-1:0] : a[MAG_W-1:0];
      ub_r   <= b[VAL_W-1] ? nb[MAG_W-1:0] : b[MAG_W-1:0];
      neg1_r <= a[VAL_W-1] ^ b[VAL_W-1];
    end
  end

  // stage 2: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= ua_r[LO_W-1:0] * ub_r[LO_W-1:0];
      lh_r   <= ua_r[LO_W-1:0] * ub_r[MAG_W-1:LO_W];
      hl_r   <= ua_r[MAG_W-1:LO_W] * ub_r[LO_W-1:0];
      hh_r   <= ua_r[MAG_W-1:LO_W] * ub_r[MAG_W-1:LO_W];
      neg2_r <= neg1_r;
    end
  end

  // stage 3: product plus rounding half
  assign sum_nxt = PROD_W'(ll_r) + (PROD_W'(lh_r) << LO_W) + (PROD_W'(hl_r) << LO_W)
                 + (PROD_W'(hh_r) << (2 * LO_W)) + RND;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sum_nxt;
      neg3_r <= neg2_r;
    end
  end

  // stage 4: rescale, clamp, sign
  assign shf     = sum_r >> SHIFT;
  assign ovf_nxt = (|shf[PROD_W-1:MAG_W]) || (shf[MAG_W-1] && (|shf[MAG_W-2:0]));
  assign mag     = ovf_nxt ? LIM_VAL_POS[MAG_W-1:0] : shf[MAG_W-1:0];
  assign p_nxt   = neg3_r ? -phd_val_t'({1'b0, mag}) : phd_val_t'({1'b0, mag});

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign p   = p_r;
  assign ovf = ovf_r;

endmodule

// ===== src/phd_div.sv =====
// ---------------------------------------------------------------------------
// phd_div
// Restoring divider unrolled into one register stage per quotient bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module phd_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [phd_pkg::DIV_BITS-1:0] dvd,
  input  logic [phd_pkg::DEN_W-1:0]    den,
  output logic [phd_pkg::DIV_BITS-1:0] quo
);

  import phd_pkg::*;

  logic [DIV_BITS-1:0] dvd_r [DIV_BITS];
  logic [DIV_BITS-1:0] quo_r [DIV_BITS];
  logic [DEN_W-1:0]    rem_r [DIV_BITS];
  logic [DEN_W-1:0]    den_r [DIV_BITS];

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
    logic [DIV_BITS-1:0] dvd_p, quo_p;
    logic [DEN_W-1:0]    rem_p, den_p;
    logic [DEN_W:0]      trial;
    logic                ge;

    if (i == 0) begin : g_first
      assign dvd_p = dvd;
      assign quo_p = '0;
      assign rem_p = '0;
      assign den_p = den;
    end else begin : g_next
      assign dvd_p = dvd_r[i-1];
      assign quo_p = quo_r[i-1];
      assign rem_p = rem_r[i-1];
      assign den_p = den_r[i-1];
    end

    // one quotient bit: shift in the next dividend bit, try to subtract
    assign trial = {rem_p, dvd_p[DIV_BITS-1]};
    assign ge    = trial >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? DEN_W'(trial - {1'b0, den_p}) : trial[DEN_W-1:0];
        quo_r[i] <= {quo_p[DIV_BITS-2:0], ge};
        dvd_r[i] <= {dvd_p[DIV_BITS-2:0], 1'b0};
        den_r[i] <= den_p;
      end
    end
  end

  assign quo = quo_r[DIV_BITS-1];

endmodule

// ===== verif/tb_pinhole_projection_with_distortion.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pinhole_projection_with_distortion
// Self-checking bench for the pinhole projection block. It writes the lens and
// camera registers in several phases, streams directed and random points
// with random gaps on both sides, predicts each pixel word in fixed point and
// compares every result word field by field, in order.
// ---------------------------------------------------------------------------

module tb_pinhole_projection_with_distortion;
  import phd_pkg::*;

  localparam int LATENCY   = 92;
  localparam int CYC_LIMIT = 400000;
  localparam longint LIM   = 64'sh1000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic        ok;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // camera and lens registers as the predictor sees them
  logic [31:0] lens_k1, lens_k2, lens_k3, lens_p1, lens_p2, foc_x, foc_y;
  logic [55:0] ctr_pp;

  pixel_t pixel_q[$];
  int mismatches = 0;
  int cycles = 0;

  pinhole_projection_with_distortion dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---- fixed-point predictor ----------------------------------------------
  function automatic longint clamp_inner(longint v, inout bit ovf);
    if (v > LIM) begin ovf = 1; return LIM; end
    if (v < -LIM) begin ovf = 1; return -LIM; end
    return v;
  endfunction

  // product rescaled by 2^s, half away from zero, clamped to +-2^60
  function automatic longint scaled_mul(longint a, longint b, int s, inout bit ovf);
    logic [127:0] p;
    logic [63:0] ua, ub;
    logic [127:0] m;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = {64'b0, ua} * {64'b0, ub};
    m = (p + (128'd1 << (s - 1))) >> s;
    if (m > LIM) begin
      m = 128'(LIM);
      ovf = 1;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint norm_quot(longint num, longint den, inout bit ovf);
    logic [95:0] q;
    logic [63:0] un;
    un = num < 0 ? -num : num;
    q = ({32'b0, un} << NORM_FRAC) / den;
    if (q > LIM) begin
      q = 96'(LIM);
      ovf = 1;
    end
    return num < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint to_pix(longint v, inout bit ovf);
    if (v > 64'sh7FFF_FFFF) begin ovf = 1; return 64'sh7FFF_FFFF; end
    if (v < -64'sh8000_0000) begin ovf = 1; return -64'sh8000_0000; end
    return v;
  endfunction

  function automatic pixel_t project_point(logic [95:0] w);
    longint x, y, z, k1, k2, k3, p1, p2, fx, fy, ppx, ppy;
    longint xn, yn, x2, y2, xy, r2, r4, r6, rad, dx, dy, t;
    bit ovf;
    pixel_t r;
    x = longint'($signed(w[31:0]));
    y = longint'($signed(w[63:32]));
    z = longint'($signed(w[95:64]));
    k1 = longint'($signed(lens_k1));
    k2 = longint'($signed(lens_k2));
    k3 = longint'($signed(lens_k3));
    p1 = longint'($signed(lens_p1));
    p2 = longint'($signed(lens_p2));
    fx = {32'b0, foc_x};
    fy = {32'b0, foc_y};
    ppx = {36'b0, ctr_pp[55:28]};
    ppy = {36'b0, ctr_pp[27:0]};
    ovf = 0;
    r = '0;
    if (z <= 0) return r;
    xn = norm_quot(x, z, ovf);
    yn = norm_quot(y, z, ovf);
    x2 = scaled_mul(xn, xn, NORM_FRAC, ovf);
    y2 = scaled_mul(yn, yn, NORM_FRAC, ovf);
    xy = scaled_mul(xn, yn, NORM_FRAC, ovf);
    r2 = clamp_inner(x2 + y2, ovf);
    r4 = scaled_mul(r2, r2, NORM_FRAC, ovf);
    r6 = scaled_mul(r4, r2, NORM_FRAC, ovf);
    rad = (64'sd1 <<< NORM_FRAC) + scaled_mul(k1, r2, 24, ovf)
        + scaled_mul(k2, r4, 24, ovf) + scaled_mul(k3, r6, 24, ovf);
    rad = clamp_inner(rad, ovf);
    t = clamp_inner(r2 + 2 * x2, ovf);
    dx = scaled_mul(xn, rad, NORM_FRAC, ovf) + 2 * scaled_mul(p1, xy, 24, ovf)
       + scaled_mul(p2, t, 24, ovf);
    dx = clamp_inner(dx, ovf);
    t = clamp_inner(r2 + 2 * y2, ovf);
    dy = scaled_mul(yn, rad, NORM_FRAC, ovf) + scaled_mul(p1, t, 24, ovf)
       + 2 * scaled_mul(p2, xy, 24, ovf);
    dy = clamp_inner(dy, ovf);
    r.px = 32'(to_pix(scaled_mul(fx, dx, NORM_FRAC, ovf) + ppx, ovf));
    r.py = 32'(to_pix(scaled_mul(fy, dy, NORM_FRAC, ovf) + ppy, ovf));
    r.ok = !ovf;
    return r;
  endfunction

  // ---- result checker with random back-pressure -----------------------------
  initial begin
    int gap;
    pixel_t want;
    forever begin
      gap = ($urandom_range(0, 7) < 2) ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h %b", out_tdata, out_tuser);
      end else begin
        want = pixel_q.pop_front();
        if (out_tdata[31:0] !== want.px || out_tdata[63:32] !== want.py
            || out_tuser[0] !== want.ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want x=%h y=%h v=%b got x=%h y=%h v=%b",
                     want.px, want.py, want.ok, out_tdata[31:0], out_tdata[63:32],
                     out_tuser[0]);
        end
      end
    end
  end

  // ---- stimulus helpers ------------------------------------------------------
  // valid stays high between back-to-back words; idle phases drop it
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = ($urandom_range(0, 7) < 2) ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixel_q.push_back(project_point({z, y, x}));
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [55:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      REG_K1: lens_k1 = v[31:0];
      REG_K2: lens_k2 = v[31:0];
      REG_K3: lens_k3 = v[31:0];
      REG_P1: lens_p1 = v[31:0];
      REG_P2: lens_p2 = v[31:0];
      REG_FX: foc_x = v[31:0];
      REG_FY: foc_y = v[31:0];
      REG_PP: ctr_pp = v;
      default: ;
    endcase
  endtask

  task automatic set_camera(logic [31:0] k1, logic [31:0] k2, logic [31:0] k3,
                            logic [31:0] p1, logic [31:0] p2, logic [31:0] fx,
                            logic [31:0] fy, logic [55:0] pp);
    write_reg(REG_K1, 56'(k1));
    write_reg(REG_K2, 56'(k2));
    write_reg(REG_K3, 56'(k3));
    write_reg(REG_P1, 56'(p1));
    write_reg(REG_P2, 56'(p2));
    write_reg(REG_FX, 56'(fx));
    write_reg(REG_FY, 56'(fy));
    write_reg(REG_PP, pp);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly points in front of the camera with modest angles
  task automatic random_points(int n);
    logic [31:0] x, y, z;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: begin x = $urandom; y = $urandom; z = $urandom; end
        1: begin x = $urandom; y = $urandom; z = -$urandom_range(0, 1000); end
        2: begin x = $urandom; y = $urandom; z = $urandom_range(1, 4); end
        default: begin
          z = $urandom_range(32'h0000_4000, 32'h7FFF_FFFF);
          x = $signed(z >> $urandom_range(0, 4)) * ($urandom_range(0, 1) ? 1 : -1);
          y = $signed(z >> $urandom_range(0, 4)) * ($urandom_range(0, 1) ? 1 : -1);
          x = x ^ $urandom_range(0, 32'hFFFF);
          y = y ^ $urandom_range(0, 32'hFFFF);
        end
      endcase
      send_point(x, y, z);
    end
  endtask

  // ---- tests -----------------------------------------------------------------
  task automatic test_reset_defaults;
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_point(32'h1234_0000, 32'h0000_0000, 32'h0000_0000);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_distortion_directed;
    set_camera(32'h0100_0000, 32'hFF80_0000, 32'h0040_0000, 32'h0001_0000,
               32'hFFFF_0000, 32'h0320_0000, 32'h0320_0000,
               {28'h0140_0000, 28'h00F0_0000});
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0010_0000);
    send_point(32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000);
    send_point(32'h0000_0000, 32'h8000_0000, 32'h0000_0100);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    drain();
    // extreme coefficients and focal lengths
    set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 56'hFF_FFFF_FFFF_FFFF);
    send_point(32'h0000_1000, 32'hFFFF_F000, 32'h0001_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_point(32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF);
    drain();
  endtask

  task automatic test_random_phases;
    set_camera(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
               32'h0000_0000, 32'h0400_0000, 32'h0400_0000, 56'h0);
    random_points(400);
    // sender holds off until everything is back
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    random_points(100);
    drain();
    set_camera(32'hFF99_0000, 32'h0010_0000, 32'hFFFF_8000, 32'h0000_4000,
               32'hFFFF_C000, 32'h0280_0000, 32'h0260_0000,
               {28'h0A00_0000, 28'h0780_0000});
    random_points(500);
    drain();
    repeat (3) begin
      set_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, 56'({$urandom, $urandom}));
      random_points(230);
      drain();
    end
  endtask

  initial begin
    lens_k1 = '0; lens_k2 = '0; lens_k3 = '0; lens_p1 = '0; lens_p2 = '0;
    foc_x = 32'h0001_0000; foc_y = 32'h0001_0000; ctr_pp = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_distortion_directed();
    test_random_phases();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
